// ===== rtl/core/pngu_pkg.sv =====
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and constants for the PNG RGBA8 scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package pngu_pkg;

    // Row geometry
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WCFG_W    = 13;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Short queues (item queue and result queue)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Filter types; every unknown code is folded into FILT_RAW
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_RAW   = 3'd7
    } t_filter;

    // Byte position within a pixel, in stream order
    typedef enum logic [1:0] {
        LANE_R = 2'd0,
        LANE_G = 2'd1,
        LANE_B = 2'd2,
        LANE_A = 2'd3
    } t_lane;

    // One classified sample byte, front to back
    typedef struct packed {
        logic [7:0]       data;
        t_lane            lane;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_filter          kind;
        logic             prior_ok;
        logic             last_row;
        logic             last_img;
    } t_item;

    // One finished pixel
    typedef struct packed {
        logic [31:0]      pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_row;
        logic             last_img;
        logic             skipped;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/png_rgba8_scanline_unfilter.sv =====
// A pixel reaches the result ports through the execute stage and the result queue once its alpha byte is taken.
// The unit takes one byte per cycle while full is low, plus one filter byte per row.
// The prior-row store has one read and one write port, so each byte's read never waits.
// Reset (i_rst_n low, synchronous) empties both queues, returns to a filter byte
// at row 0 and sets width and height to 1; the prior-row store is not cleared.
// ----------------------------------------------------------------------------
// png_rgba8_scanline_unfilter
// PNG scanline unfilter for 8-bit RGBA: front classifier, item queue and
// reconstruction back end with the prior-row store.
// ----------------------------------------------------------------------------
`default_nettype none

module png_rgba8_scanline_unfilter import pngu_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            i_data_byte,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [31:0]                o_pixel_argb,
    output logic [COL_W-1:0]           o_column,
    output logic [ROW_W-1:0]           o_row_index,
    output logic                       o_last_in_row,
    output logic                       o_last_in_image,
    output logic                       o_row_skipped
);

    logic    q_push, q_pop, q_full, q_empty;
    t_item   q_in, q_head;
    t_result result;

    assign full = q_full;

    // Front: byte classification
    pngu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_item      (q_in)
    );

    // Decoupling queue
    pngu_item_q u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: reconstruction and result buffer
    pngu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_pixel_argb    = result.pixel;
    assign o_column        = result.col;
    assign o_row_index     = result.row;
    assign o_last_in_row   = result.last_row;
    assign o_last_in_image = result.last_img;
    assign o_row_skipped   = result.skipped;

endmodule

`default_nettype wire

// ===== rtl/core/pngu_front.sv =====
// ----------------------------------------------------------------------------
// pngu_front
// Accepts stream bytes, tracks filter type, lane, column and row, and turns
// each sample byte into a classified item for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_front import pngu_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_item                      o_item
);

    typedef enum logic [1:0] {
        FS_FILTER = 2'b01,
        FS_SAMPLE = 2'b10
    } t_front_state;

    t_front_state     r_state, n_state;
    t_filter          r_kind, n_kind;
    t_lane            r_lane, n_lane;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_prior_ok, n_prior_ok;
    logic [WCFG_W-1:0] r_width;
    logic [ROW_W-1:0]  r_height;

    logic              accept;
    logic [WCFG_W-1:0] w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              last_row, last_img;
    t_filter           kind_in;

    assign accept = i_push && !i_q_full;

    // Clamp the configured geometry
    always_comb begin
        if (r_width == '0) begin
            w_eff = WCFG_W'(1);
        end else if (r_width > WCFG_W'(MAX_WIDTH)) begin
            w_eff = WCFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? ROW_W'(1) : r_height;
    end

    assign last_row = ({1'b0, r_col} + WCFG_W'(1)) >= w_eff;
    assign last_img = last_row && (({1'b0, r_row} + 17'd1) >= {1'b0, h_eff});

    // Decode the filter byte
    always_comb begin
        case (i_data_byte)
            8'd0:    kind_in = FILT_NONE;
            8'd1:    kind_in = FILT_SUB;
            8'd2:    kind_in = FILT_UP;
            8'd3:    kind_in = FILT_AVG;
            8'd4:    kind_in = FILT_PAETH;
            default: kind_in = FILT_RAW;
        endcase
    end

    // Classified item for the queue
    always_comb begin
        o_item.data     = i_data_byte;
        o_item.lane     = r_lane;
        o_item.col      = r_col;
        o_item.row      = r_row;
        o_item.kind     = r_kind;
        o_item.prior_ok = r_prior_ok;
        o_item.last_row = last_row;
        o_item.last_img = last_img;
    end

    assign o_q_push = accept && (r_state == FS_SAMPLE);

    // Position tracking
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_lane     = r_lane;
        n_col      = r_col;
        n_row      = r_row;
        n_prior_ok = r_prior_ok;
        if (accept) begin
            case (r_state)
                FS_FILTER: begin
                    n_kind  = kind_in;
                    n_state = FS_SAMPLE;
                    n_lane  = LANE_R;
                    n_col   = '0;
                    if (r_row == '0) begin
                        n_prior_ok = 1'b0;
                    end
                end
                FS_SAMPLE: begin
                    if (r_lane != LANE_A) begin
                        n_lane = t_lane'(r_lane + 2'd1);
                    end else begin
                        n_lane = LANE_R;
                        if (last_row) begin
                            n_state = FS_FILTER;
                            n_col   = '0;
                            n_row   = last_img ? '0 : r_row + ROW_W'(1);
                            if (r_kind != FILT_RAW) begin
                                n_prior_ok = 1'b1;
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                    end
                end
                default: begin
                    n_state = FS_FILTER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_FILTER;
            r_kind     <= FILT_NONE;
            r_lane     <= LANE_R;
            r_col      <= '0;
            r_row      <= '0;
            r_prior_ok <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_lane     <= n_lane;
            r_col      <= n_col;
            r_row      <= n_row;
            r_prior_ok <= n_prior_ok;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCFG_W'(1);
            r_height <= ROW_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[WCFG_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pngu_item_q.sv =====
// ----------------------------------------------------------------------------
// pngu_item_q
// Short queue of classified sample bytes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_item_q import pngu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_head
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pngu_back.sv =====
// ----------------------------------------------------------------------------
// pngu_back
// Reconstructs sample bytes against the prior row, assembles ARGB pixels,
// updates the prior-row store and buffers finished pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_back import pngu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_item i_head,
    output logic       o_q_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_result    o_result
);

    // Byte of a packed ARGB word for a given stream lane
    function automatic logic [7:0] lane_byte(input logic [31:0] px, input t_lane l);
        logic [7:0] r;
        case (l)
            LANE_R:  r = px[23:16];
            LANE_G:  r = px[15:8];
            LANE_B:  r = px[7:0];
            LANE_A:  r = px[31:24];
            default: r = px[31:24];
        endcase
        return r;
    endfunction

    // Paeth predictor on one byte
    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] da, db, dc;
        logic signed [9:0] pa, pb, pc;
        logic [7:0]        r;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? -da : da;
        pb = (db < 0) ? -db : db;
        pc = (dc < 0) ? -dc : dc;
        if (pa <= pb && pa <= pc) begin
            r = a;
        end else if (pb <= pc) begin
            r = b;
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Prior-row store
    logic [31:0] r_store [MAX_WIDTH];
    logic [31:0] r_rd;

    // Execute stage
    logic        r_e2_valid;
    t_item       r_e2;
    logic        r_fwd_hit;
    logic [31:0] r_fwd_data;
    logic [23:0] r_partial;
    logic [31:0] r_left;
    logic [31:0] r_upleft;

    // Result queue
    t_result           r_oq [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic        oq_full;
    logic        e2_emit, en, store_we, oq_push, oq_pop;
    logic [31:0] up;
    logic [7:0]  a, b, c, pred, v;
    logic [8:0]  ab_sum;
    logic [31:0] pixel;
    t_result     res;

    assign oq_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty  = (r_cnt == '0);
    assign e2_emit  = r_e2_valid && (r_e2.lane == LANE_A);
    assign en       = !(e2_emit && oq_full);
    assign o_q_pop  = en && !i_q_empty;
    assign store_we = en && e2_emit && (r_e2.kind != FILT_RAW);
    assign oq_push  = en && e2_emit;
    assign oq_pop   = i_pop && !o_empty;

    // Upper pixel: zero without a valid prior row; bypass a write to the same column in the read cycle
    always_comb begin
        if (!r_e2.prior_ok) begin
            up = '0;
        end else if (r_fwd_hit) begin
            up = r_fwd_data;
        end else begin
            up = r_rd;
        end
    end

    // Neighbor bytes; left edge sees zeros
    assign a = (r_e2.col == '0) ? 8'd0 : lane_byte(r_left, r_e2.lane);
    assign b = lane_byte(up, r_e2.lane);
    assign c = (r_e2.col == '0) ? 8'd0 : lane_byte(r_upleft, r_e2.lane);
    assign ab_sum = {1'b0, a} + {1'b0, b};

    // Predictor select
    always_comb begin
        case (r_e2.kind)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_pred(a, b, c);
            default:    pred = 8'd0;
        endcase
    end

    assign v     = r_e2.data + pred;
    assign pixel = {v, r_partial};

    always_comb begin
        res.pixel    = pixel;
        res.col      = r_e2.col;
        res.row      = r_e2.row;
        res.last_row = r_e2.last_row;
        res.last_img = r_e2.last_img;
        res.skipped  = (r_e2.kind == FILT_RAW);
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_e2.col] <= pixel;
        end
        if (en) begin
            r_rd <= r_store[i_head.col];
        end
    end

    // Execute stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid <= 1'b0;
        end else if (en) begin
            r_e2_valid <= !i_q_empty;
        end
    end

    // Execute stage payload and bypass capture
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e2       <= i_head;
            r_fwd_hit  <= store_we && (r_e2.col == i_head.col);
            r_fwd_data <= pixel;
        end
    end

    // Pixel assembly and left neighbors
    always_ff @(posedge i_clk) begin
        if (en && r_e2_valid) begin
            case (r_e2.lane)
                LANE_R: r_partial[23:16] <= v;
                LANE_G: r_partial[15:8]  <= v;
                LANE_B: r_partial[7:0]   <= v;
                LANE_A: begin
                    r_left   <= pixel;
                    r_upleft <= up;
                end
                default: r_partial <= r_partial;
            endcase
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_wp] <= res;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (oq_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    assign o_result = r_oq[r_rp];

endmodule

`default_nettype wire

// ===== rtl/core/pngu_checker.sv =====
// ----------------------------------------------------------------------------
// pngu_checker
// Port-level checks on result ordering of the scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_checker import pngu_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [COL_W-1:0] o_column,
    input wire logic [ROW_W-1:0] o_row_index,
    input wire logic             o_last_in_row,
    input wire logic             o_last_in_image
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // Image end is always a row end
    a_img_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last_in_image |-> o_last_in_row)
        else $error("last_in_image without last_in_row");

    // Within a row, columns advance by one on the same row
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_in_row) ##1 !empty |->
        (o_column == COL_W'($past(o_column) + COL_W'(1))) &&
        (o_row_index == $past(o_row_index)))
        else $error("column did not advance by one");

    // A new row starts at column zero
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_in_row) ##1 !empty |-> (o_column == '0))
        else $error("row did not start at column zero");

    // A new image starts at row zero
    a_img_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_in_image) ##1 !empty |-> (o_row_index == '0))
        else $error("image did not restart at row zero");

endmodule

bind png_rgba8_scanline_unfilter pngu_checker u_pngu_checker (.*);

`default_nettype wire
